// File: rtl/fpr2_pkg.sv
// Shared types and constants of the radix-2 fixed-point FFT unit.
package fpr2_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_BITS  = 14;
    localparam int INDEX_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int LOG2_W     = 4;
    localparam int ROM_W      = FRAC_BITS + 1;

    // Item kinds on the input channel.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOG2_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE   = 2'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } cplx_t;

endpackage

// File: rtl/fpr2_cmul.sv
// Sequential complex multiplier with one shared 16x16 multiplier and Q14 scaling.
module fpr2_cmul
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  fpr2_pkg::cplx_t      x,
    input  fpr2_pkg::cplx_t      w,
    output logic                 done,
    output fpr2_pkg::cplx_t      v
);

    localparam int PW = 2 * fpr2_pkg::SAMPLE_W;
    localparam int AW = PW + 1;

    logic [2:0]                         step_reg;
    logic                               done_reg;
    fpr2_pkg::cplx_t                    x_reg;
    fpr2_pkg::cplx_t                    w_reg;
    logic signed [PW-1:0]               prod_reg;
    logic signed [AW-1:0]               acc_r_reg;
    logic signed [AW-1:0]               acc_i_reg;
    logic signed [fpr2_pkg::SAMPLE_W-1:0] mul_a;
    logic signed [fpr2_pkg::SAMPLE_W-1:0] mul_b;
    logic signed [AW-1:0]               bias_r;
    logic signed [AW-1:0]               bias_i;
    logic signed [AW-1:0]               shr_r;
    logic signed [AW-1:0]               shr_i;

    // Operand order: xr*wr, xi*wi, xr*wi, xi*wr.
    always_comb
    begin
        case (step_reg)
            3'd1:
            begin
                mul_a = x_reg.re;
                mul_b = w_reg.re;
            end
            3'd2:
            begin
                mul_a = x_reg.im;
                mul_b = w_reg.im;
            end
            3'd3:
            begin
                mul_a = x_reg.re;
                mul_b = w_reg.im;
            end
            default:
            begin
                mul_a = x_reg.im;
                mul_b = w_reg.re;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= 3'd1;
            end
            else if (step_reg == 3'd5)
            begin
                step_reg <= 3'd0;
                done_reg <= 1'b1;
            end
            else if (step_reg != 3'd0)
            begin
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x;
            w_reg <= w;
        end
        prod_reg <= mul_a * mul_b;
        case (step_reg)
            3'd2:    acc_r_reg <= AW'(prod_reg);
            3'd3:    acc_r_reg <= acc_r_reg - AW'(prod_reg);
            3'd4:    acc_i_reg <= AW'(prod_reg);
            3'd5:    acc_i_reg <= acc_i_reg + AW'(prod_reg);
            default: ;
        endcase
    end

    // Divide by 2^14 truncating toward zero, then wrap to 16 bits.
    assign bias_r = acc_r_reg[AW-1] ? AW'((1 << fpr2_pkg::FRAC_BITS) - 1) : '0;
    assign bias_i = acc_i_reg[AW-1] ? AW'((1 << fpr2_pkg::FRAC_BITS) - 1) : '0;
    assign shr_r  = (acc_r_reg + bias_r) >>> fpr2_pkg::FRAC_BITS;
    assign shr_i  = (acc_i_reg + bias_i) >>> fpr2_pkg::FRAC_BITS;
    assign v.re   = shr_r[fpr2_pkg::SAMPLE_W-1:0];
    assign v.im   = shr_i[fpr2_pkg::SAMPLE_W-1:0];
    assign done   = done_reg;

endmodule

// File: rtl/fixed_point_radix2_fft_unit.sv
// Top level of the in-place radix-2 decimation-in-time fixed-point FFT unit.
//
//  Channel   Signals                                        Direction
//  ------    -------------------------------------------    ---------
//  in        in_valid/in_ready, kind, sample_real/imag      into block
//  out       out_valid/out_ready, out_real/imag, out_index,  out of block
//            last_bin, not_ready
//  cfg       cfg_valid/cfg_ready, cfg_index, cfg_data       into block
//
// A load item is written to the sample memory as it is accepted; a read
// item of a finished frame passes through the read state before its result
// is registered. The load that completes a frame of N = 2^log2_size samples
// starts the transform, during which in_ready and cfg_ready stay low: a
// bit-reversal pass, N/2*log2(N) butterflies through the sample memory and
// the shared multiplier, and a scaling pass for the inverse transform.
// Reset clears the control and output registers; the sample memory holds
// no reset value. A stalled result holds in the output register and the
// block takes no new item until it is taken.
module fixed_point_radix2_fft_unit
#(
    parameter int MAX_POINTS = 1024
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 kind,
    input  logic signed [fpr2_pkg::SAMPLE_W-1:0] sample_real,
    input  logic signed [fpr2_pkg::SAMPLE_W-1:0] sample_imag,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [fpr2_pkg::SAMPLE_W-1:0] out_real,
    output logic signed [fpr2_pkg::SAMPLE_W-1:0] out_imag,
    output logic [fpr2_pkg::INDEX_W-1:0]         out_index,
    output logic                                 last_bin,
    output logic                                 not_ready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fpr2_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fpr2_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int AW      = $clog2(MAX_POINTS);
    localparam int CW      = AW + 1;
    localparam int LW      = $clog2(AW + 1);
    localparam int ROM_LOG = (AW < 2) ? 2 : AW;
    localparam int RW      = ROM_LOG - 1;
    localparam int QTR     = 2 ** (ROM_LOG - 2);
    localparam int SW      = fpr2_pkg::SAMPLE_W;
    localparam int ONE_Q   = 1 << fpr2_pkg::FRAC_BITS;
    localparam real ANG_STEP = 3.14159265358979323846 / (2.0 * QTR);

    typedef logic [fpr2_pkg::ROM_W-1:0] rom_t [0:QTR];

    // Quarter-wave sine table, trunc(16384 * sin(pi/2 * m / QTR)).
    function automatic rom_t build_rom();
        rom_t r;
        real  a;
        for (int m = 0; m <= QTR; m++)
        begin
            if (m == 0)
            begin
                r[m] = '0;
            end
            else if (m == QTR)
            begin
                r[m] = fpr2_pkg::ROM_W'(ONE_Q);
            end
            else
            begin
                a    = ANG_STEP * m;
                r[m] = fpr2_pkg::ROM_W'($rtoi(ONE_Q * $sin(a)));
            end
        end
        return r;
    endfunction

    localparam rom_t SIN_ROM = build_rom();

    function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        for (int k = 0; k < AW; k++)
        begin
            r[k] = a[AW-1-k];
        end
        return r;
    endfunction

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_BR_I,
        ST_BR_J,
        ST_BR_WI,
        ST_BR_WJ,
        ST_BF_P,
        ST_BF_Q,
        ST_BF_X,
        ST_BF_MUL,
        ST_BF_WQ,
        ST_DV_RD,
        ST_DV_WR
    } state_t;

    state_t                         state_reg;
    logic [fpr2_pkg::LOG2_W-1:0]    log2_size_reg;
    logic                           inverse_reg;
    logic [CW-1:0]                  load_count_reg;
    logic [CW-1:0]                  read_ptr_reg;
    logic                           done_reg;
    logic [AW-1:0]                  idx_reg;
    logic [LW-1:0]                  stage_reg;
    logic [AW-1:0]                  bfly_reg;
    fpr2_pkg::cplx_t                tmp_reg;
    fpr2_pkg::cplx_t                u_reg;
    logic signed [SW-1:0]           wr_reg;
    logic                           out_valid_reg;
    logic signed [SW-1:0]           out_real_reg;
    logic signed [SW-1:0]           out_imag_reg;
    logic [fpr2_pkg::INDEX_W-1:0]   out_index_reg;
    logic                           last_bin_reg;
    logic                           not_ready_reg;

    // Sample memory and twiddle ROM.
    logic [2*SW-1:0]                mem [0:MAX_POINTS-1];
    logic [2*SW-1:0]                mem_rdata;
    logic [AW-1:0]                  mem_raddr;
    logic [AW-1:0]                  mem_waddr;
    logic [2*SW-1:0]                mem_wdata;
    logic                           mem_we;
    logic [fpr2_pkg::ROM_W-1:0]     rom_q;
    logic [RW-1:0]                  rom_addr;

    logic [LW-1:0]                  eff_lg;
    logic [CW-1:0]                  n_pts;
    logic [CW-1:0]                  n_half;
    logic [AW-1:0]                  rev_idx;
    logic                           idx_last;
    logic                           in_acc;
    logic                           cfg_acc;
    logic                           restart;
    logic [CW-1:0]                  load_base;
    logic [CW-1:0]                  load_next;
    logic [AW-1:0]                  half_mask;
    logic [AW-1:0]                  k_idx;
    logic [AW-1:0]                  p_idx;
    logic [AW-1:0]                  q_idx;
    logic [RW-1:0]                  tw_j;
    logic                           tw_hi;
    logic [RW-1:0]                  cos_addr;
    logic [RW-1:0]                  sin_addr;
    logic signed [SW-1:0]           rom_s;
    logic signed [SW-1:0]           wi_val;
    logic                           cm_start;
    fpr2_pkg::cplx_t                cm_x;
    fpr2_pkg::cplx_t                cm_w;
    logic                           cm_done;
    fpr2_pkg::cplx_t                cm_v;
    fpr2_pkg::cplx_t                rd_c;
    logic signed [SW:0]             div_re;
    logic signed [SW:0]             div_im;
    logic signed [SW:0]             div_bias;
    logic signed [SW:0]             div_bias_im;

    // A length above the memory size saturates to the memory size.
    assign eff_lg  = (log2_size_reg > fpr2_pkg::LOG2_W'(AW)) ? LW'(AW) : LW'(log2_size_reg);
    assign n_pts   = CW'(1) << eff_lg;
    assign n_half  = n_pts >> 1;
    assign rev_idx = bit_rev(idx_reg) >> (AW - int'(eff_lg));
    assign idx_last = ({1'b0, idx_reg} == n_pts - CW'(1));

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg && !cfg_valid;
    assign in_acc    = in_valid && in_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;

    // A load after a finished or overfull frame starts a new frame at entry 0.
    assign restart   = done_reg || (load_count_reg >= n_pts);
    assign load_base = restart ? '0 : load_count_reg;
    assign load_next = load_base + CW'(1);

    // Butterfly addressing: flat index split into group and offset within it.
    assign half_mask = (AW'(1) << stage_reg) - AW'(1);
    assign k_idx     = bfly_reg & half_mask;
    assign p_idx     = ((bfly_reg >> stage_reg) << (stage_reg + LW'(1))) | k_idx;
    assign q_idx     = p_idx | (AW'(1) << stage_reg);

    // Twiddle angle index on the full table grid.
    assign tw_j     = RW'(k_idx) << (RW - int'(stage_reg));
    assign tw_hi    = (tw_j > RW'(QTR));
    assign cos_addr = tw_hi ? (tw_j - RW'(QTR)) : (RW'(QTR) - tw_j);
    assign sin_addr = tw_hi ? RW'(CW'(2 * QTR) - CW'(tw_j)) : tw_j;
    assign rom_s    = SW'({1'b0, rom_q});
    assign wi_val   = inverse_reg ? rom_s : -rom_s;

    assign rd_c        = mem_rdata;
    assign div_bias    = rd_c.re[SW-1] ? (SW+1)'(n_pts - CW'(1)) : '0;
    assign div_bias_im = rd_c.im[SW-1] ? (SW+1)'(n_pts - CW'(1)) : '0;
    assign div_re      = ((SW+1)'(rd_c.re) + div_bias) >>> eff_lg;
    assign div_im      = ((SW+1)'(rd_c.im) + div_bias_im) >>> eff_lg;

    assign cm_x = mem_rdata;
    assign cm_w = '{re: wr_reg, im: wi_val};

    always_comb
    begin
        mem_raddr = read_ptr_reg[AW-1:0];
        mem_waddr = idx_reg;
        mem_wdata = mem_rdata;
        mem_we    = 1'b0;
        rom_addr  = cos_addr;
        cm_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                mem_waddr = load_base[AW-1:0];
                mem_wdata = {sample_real, sample_imag};
                mem_we    = in_acc && (kind == fpr2_pkg::KIND_LOAD);
            end
            ST_BR_I:
            begin
                mem_raddr = idx_reg;
            end
            ST_BR_J:
            begin
                mem_raddr = rev_idx;
            end
            ST_BR_WI:
            begin
                mem_we    = 1'b1;
            end
            ST_BR_WJ:
            begin
                mem_we    = 1'b1;
                mem_waddr = rev_idx;
                mem_wdata = tmp_reg;
            end
            ST_BF_P:
            begin
                mem_raddr = p_idx;
            end
            ST_BF_Q:
            begin
                mem_raddr = q_idx;
                rom_addr  = sin_addr;
            end
            ST_BF_X:
            begin
                cm_start  = 1'b1;
            end
            ST_BF_MUL:
            begin
                mem_we    = cm_done;
                mem_waddr = p_idx;
                mem_wdata = {u_reg.re + cm_v.re, u_reg.im + cm_v.im};
            end
            ST_BF_WQ:
            begin
                mem_we    = 1'b1;
                mem_waddr = q_idx;
                mem_wdata = {u_reg.re - cm_v.re, u_reg.im - cm_v.im};
            end
            ST_DV_RD:
            begin
                mem_raddr = idx_reg;
            end
            ST_DV_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {div_re[SW-1:0], div_im[SW-1:0]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_raddr];
        rom_q     <= SIN_ROM[rom_addr];
    end

    fpr2_cmul u_cmul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cm_start),
        .x     (cm_x),
        .w     (cm_w),
        .done  (cm_done),
        .v     (cm_v)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            log2_size_reg  <= fpr2_pkg::LOG2_W'(10);
            inverse_reg    <= 1'b0;
            load_count_reg <= '0;
            read_ptr_reg   <= '0;
            done_reg       <= 1'b0;
            idx_reg        <= '0;
            stage_reg      <= '0;
            bfly_reg       <= '0;
            tmp_reg        <= '0;
            u_reg          <= '0;
            wr_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_real_reg   <= '0;
            out_imag_reg   <= '0;
            out_index_reg  <= '0;
            last_bin_reg   <= 1'b0;
            not_ready_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cfg_acc)
                    begin
                        case (cfg_index)
                            fpr2_pkg::CFG_LOG2_SIZE:
                            begin
                                log2_size_reg  <= cfg_data;
                                load_count_reg <= '0;
                                read_ptr_reg   <= '0;
                                done_reg       <= 1'b0;
                            end
                            fpr2_pkg::CFG_INVERSE:
                            begin
                                inverse_reg    <= cfg_data[0];
                                load_count_reg <= '0;
                                read_ptr_reg   <= '0;
                                done_reg       <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                    else if (in_acc && (kind == fpr2_pkg::KIND_LOAD))
                    begin
                        load_count_reg <= load_next;
                        if (restart)
                        begin
                            done_reg     <= 1'b0;
                            read_ptr_reg <= '0;
                        end
                        if (load_next == n_pts)
                        begin
                            idx_reg   <= '0;
                            state_reg <= ST_BR_I;
                        end
                    end
                    else if (in_acc)
                    begin
                        if (!done_reg || (read_ptr_reg >= n_pts))
                        begin
                            out_real_reg  <= '0;
                            out_imag_reg  <= '0;
                            out_index_reg <= '0;
                            last_bin_reg  <= 1'b0;
                            not_ready_reg <= 1'b1;
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    out_real_reg  <= rd_c.re;
                    out_imag_reg  <= rd_c.im;
                    out_index_reg <= fpr2_pkg::INDEX_W'(read_ptr_reg);
                    last_bin_reg  <= (read_ptr_reg == n_pts - CW'(1));
                    not_ready_reg <= 1'b0;
                    out_valid_reg <= 1'b1;
                    if (read_ptr_reg + CW'(1) >= n_pts)
                    begin
                        done_reg       <= 1'b0;
                        load_count_reg <= '0;
                        read_ptr_reg   <= '0;
                    end
                    else
                    begin
                        read_ptr_reg <= read_ptr_reg + CW'(1);
                    end
                    state_reg <= ST_IDLE;
                end
                ST_BR_I, ST_BR_WJ:
                begin
                    if ((state_reg == ST_BR_I) && (idx_reg < rev_idx))
                    begin
                        state_reg <= ST_BR_J;
                    end
                    else if (!idx_last)
                    begin
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= ST_BR_I;
                    end
                    else if (eff_lg != '0)
                    begin
                        stage_reg <= '0;
                        bfly_reg  <= '0;
                        state_reg <= ST_BF_P;
                    end
                    else if (inverse_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_DV_RD;
                    end
                    else
                    begin
                        done_reg     <= 1'b1;
                        read_ptr_reg <= '0;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_BR_J:
                begin
                    tmp_reg   <= mem_rdata;
                    state_reg <= ST_BR_WI;
                end
                ST_BR_WI:
                begin
                    state_reg <= ST_BR_WJ;
                end
                ST_BF_P:
                begin
                    state_reg <= ST_BF_Q;
                end
                ST_BF_Q:
                begin
                    u_reg     <= mem_rdata;
                    wr_reg    <= tw_hi ? -rom_s : rom_s;
                    state_reg <= ST_BF_X;
                end
                ST_BF_X:
                begin
                    state_reg <= ST_BF_MUL;
                end
                ST_BF_MUL:
                begin
                    if (cm_done)
                    begin
                        state_reg <= ST_BF_WQ;
                    end
                end
                ST_BF_WQ:
                begin
                    if (CW'(bfly_reg) == n_half - CW'(1))
                    begin
                        bfly_reg <= '0;
                        if (stage_reg == eff_lg - LW'(1))
                        begin
                            if (inverse_reg)
                            begin
                                idx_reg   <= '0;
                                state_reg <= ST_DV_RD;
                            end
                            else
                            begin
                                done_reg     <= 1'b1;
                                read_ptr_reg <= '0;
                                state_reg    <= ST_IDLE;
                            end
                        end
                        else
                        begin
                            stage_reg <= stage_reg + LW'(1);
                            state_reg <= ST_BF_P;
                        end
                    end
                    else
                    begin
                        bfly_reg  <= bfly_reg + AW'(1);
                        state_reg <= ST_BF_P;
                    end
                end
                ST_DV_RD:
                begin
                    state_reg <= ST_DV_WR;
                end
                ST_DV_WR:
                begin
                    if (idx_last)
                    begin
                        done_reg     <= 1'b1;
                        read_ptr_reg <= '0;
                        state_reg    <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= ST_DV_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_real  = out_real_reg;
    assign out_imag  = out_imag_reg;
    assign out_index = out_index_reg;
    assign last_bin  = last_bin_reg;
    assign not_ready = not_ready_reg;

endmodule

// File: tb/tb_fixed_point_radix2_fft_unit.sv
// Self-checking testbench of the radix-2 fixed-point FFT unit with its own transform predictor.
`timescale 1ns / 100ps

module tb_fixed_point_radix2_fft_unit;

    localparam int POINTS       = 1024;
    localparam int QUARTER      = POINTS / 4;
    localparam int TARGET_ITEMS = 1450;
    localparam int MAX_PRINTS   = 30;

    // One expected (or observed) result item of the output channel.
    typedef struct {
        logic signed [fpr2_pkg::SAMPLE_W-1:0] re;
        logic signed [fpr2_pkg::SAMPLE_W-1:0] im;
        logic [fpr2_pkg::INDEX_W-1:0]         idx;
        logic                                 last;
        logic                                 nrdy;
    } bin_t;

    // The scoreboard keeps its own copy of the sample memory, the frame
    // counters and both registers, and runs the transform itself when a
    // frame is complete. Each read item queues exactly one expected bin.
    class fft_bin_scoreboard;
        int   sine_rom[QUARTER + 1];
        int   mem_re[POINTS];
        int   mem_im[POINTS];
        int   size_log2;
        bit   inv;
        int   loaded;
        int   rd_ptr;
        bit   done;
        bin_t expected_bins[$];
        int   errors;
        int   checked;
        int   not_ready_seen;
        int   frames;

        function new();
            size_log2 = 10;
            inv = 0;
            errors = 0;
            checked = 0;
            not_ready_seen = 0;
            frames = 0;
            clear_frame();
            for (int m = 0; m <= QUARTER; m++)
                sine_rom[m] = quarter_sine(m);
        endfunction

        function void clear_frame();
            loaded = 0;
            rd_ptr = 0;
            done = 0;
        endfunction

        // Bits 123 to 60 of a Q60 by Q60 product, which keeps the result in Q60.
        function bit [63:0] q60_mul(bit [63:0] a, bit [63:0] b);
            bit [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return p[123:60];
        endfunction

        // trunc(16384 * sin(pi/2 * m / QUARTER)) from a Taylor series in Q60.
        function int quarter_sine(int m);
            bit [63:0] pi_q60, ph, pl, x, x2, term, sum;
            int k;
            if (m == 0) return 0;
            if (m >= QUARTER) return 1 << fpr2_pkg::FRAC_BITS;
            pi_q60 = 64'h3243F6A8885A308D;
            ph = pi_q60 >> 32;
            pl = pi_q60 & 64'hFFFF_FFFF;
            // The angle step is pi / (POINTS / 2), and POINTS / 2 is 2^9.
            x = ((ph * m) << (32 - 9)) + ((pl * m) >> 9);
            x2 = q60_mul(x, x);
            term = x;
            sum = x;
            k = 1;
            while (k <= 30 && term != 0) begin
                term = q60_mul(term, x2) / (64'(2 * k) * 64'(2 * k + 1));
                if (k % 2 == 1) sum = sum - term;
                else sum = sum + term;
                k++;
            end
            return int'(sum >> (60 - fpr2_pkg::FRAC_BITS));
        endfunction

        function int wrap16(longint v);
            logic signed [15:0] w;
            w = v[15:0];
            return int'(w);
        endfunction

        function int used_log2();
            return (size_log2 > 10) ? 10 : size_log2;
        endfunction

        function void twiddle(int t, int lg, output int wr, output int wi);
            int j, c, s;
            j = t * (POINTS >> lg);
            if (j <= QUARTER) begin
                c = sine_rom[QUARTER - j];
                s = sine_rom[j];
            end
            else begin
                c = -sine_rom[(j - QUARTER) % (QUARTER + 1)];
                s = sine_rom[(2 * QUARTER - j) % (QUARTER + 1)];
            end
            wr = c;
            wi = inv ? s : -s;
        endfunction

        function void transform(int lg);
            int n, j, x, tr, ti, p, q, wr, wi, vr, vi, ur, ui, span;
            longint pr, pim;
            n = 1 << lg;
            for (int i = 0; i < n; i++) begin
                j = 0;
                x = i;
                for (int b = 0; b < lg; b++) begin
                    j = (j << 1) | (x & 1);
                    x = x >> 1;
                end
                if (i < j) begin
                    tr = mem_re[i];
                    ti = mem_im[i];
                    mem_re[i] = mem_re[j];
                    mem_im[i] = mem_im[j];
                    mem_re[j] = tr;
                    mem_im[j] = ti;
                end
            end
            for (int half = 1; half < n; half = half * 2) begin
                span = n / (2 * half);
                for (int g = 0; g < n; g += 2 * half) begin
                    for (int k = 0; k < half; k++) begin
                        p = g + k;
                        q = p + half;
                        ur = mem_re[p];
                        ui = mem_im[p];
                        pr = mem_re[q];
                        pim = mem_im[q];
                        twiddle(span * k, lg, wr, wi);
                        // Division truncates toward zero before the wrap.
                        vr = wrap16((pr * wr - pim * wi) / 64'sd16384);
                        vi = wrap16((pr * wi + pim * wr) / 64'sd16384);
                        mem_re[p] = wrap16(longint'(ur) + vr);
                        mem_im[p] = wrap16(longint'(ui) + vi);
                        mem_re[q] = wrap16(longint'(ur) - vr);
                        mem_im[q] = wrap16(longint'(ui) - vi);
                    end
                end
            end
            if (inv) begin
                for (int i = 0; i < n; i++) begin
                    mem_re[i] = mem_re[i] / n;
                    mem_im[i] = mem_im[i] / n;
                end
            end
        endfunction

        function void write_reg(logic [fpr2_pkg::CFG_IDX_W-1:0] idx,
                                logic [fpr2_pkg::CFG_DATA_W-1:0] data);
            if (idx == fpr2_pkg::CFG_LOG2_SIZE) size_log2 = data;
            else if (idx == fpr2_pkg::CFG_INVERSE) inv = data[0];
            else return;
            clear_frame();
        endfunction

        // Notes one accepted input item and queues the bin it produces, if any.
        function void note_item(logic k, logic signed [15:0] re, logic signed [15:0] im);
            int lg, n;
            bin_t b;
            lg = used_log2();
            n = 1 << lg;
            if (k == fpr2_pkg::KIND_LOAD) begin
                if (done || loaded >= n) clear_frame();
                mem_re[loaded] = re;
                mem_im[loaded] = im;
                loaded++;
                if (loaded == n) begin
                    transform(lg);
                    done = 1;
                    rd_ptr = 0;
                    frames++;
                end
                return;
            end
            if (!done || rd_ptr >= n) begin
                b = '{re: '0, im: '0, idx: '0, last: 1'b0, nrdy: 1'b1};
                expected_bins.push_back(b);
                return;
            end
            b.re = mem_re[rd_ptr];
            b.im = mem_im[rd_ptr];
            b.idx = rd_ptr[fpr2_pkg::INDEX_W-1:0];
            b.last = (rd_ptr == n - 1);
            b.nrdy = 1'b0;
            expected_bins.push_back(b);
            rd_ptr++;
            if (rd_ptr >= n) clear_frame();
        endfunction

        function int pending();
            return expected_bins.size();
        endfunction

        task report(string what, int got, int want);
            if (errors < MAX_PRINTS)
                $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
            errors++;
        endtask

        task check_bin(bin_t got);
            bin_t want;
            if (expected_bins.size() == 0) begin
                report("unexpected result item", 1, 0);
                return;
            end
            want = expected_bins.pop_front();
            checked++;
            if (want.nrdy) not_ready_seen++;
            if (got.nrdy !== want.nrdy) report("not_ready", got.nrdy, want.nrdy);
            if (got.re !== want.re) report("out_real", got.re, want.re);
            if (got.im !== want.im) report("out_imag", got.im, want.im);
            if (got.idx !== want.idx) report("out_index", got.idx, want.idx);
            if (got.last !== want.last) report("last_bin", got.last, want.last);
        endtask
    endclass

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_ready;
    logic                                 kind;
    logic signed [fpr2_pkg::SAMPLE_W-1:0] sample_real;
    logic signed [fpr2_pkg::SAMPLE_W-1:0] sample_imag;
    logic                                 out_valid;
    logic                                 out_ready;
    logic signed [fpr2_pkg::SAMPLE_W-1:0] out_real;
    logic signed [fpr2_pkg::SAMPLE_W-1:0] out_imag;
    logic [fpr2_pkg::INDEX_W-1:0]         out_index;
    logic                                 last_bin;
    logic                                 not_ready;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [fpr2_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [fpr2_pkg::CFG_DATA_W-1:0]      cfg_data;

    fft_bin_scoreboard sb;
    int  items_sent;
    int  long_holds;
    bit  hold_request;

    fixed_point_radix2_fft_unit #(.MAX_POINTS(POINTS)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .sample_real(sample_real),
        .sample_imag(sample_imag),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_real   (out_real),
        .out_imag   (out_imag),
        .out_index  (out_index),
        .last_bin   (last_bin),
        .not_ready  (not_ready),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // A sample value drawn from a mix of full-range noise, small values that
    // keep the butterflies mostly clear of wrapping, the field extremes, zero and -1.
    function automatic logic signed [15:0] draw_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) return 16'($urandom);
        if (pick < 8) return 16'(int'($urandom_range(0, 4095)) - 2048);
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    // Offers one item after a random gap and returns at the edge at which
    // it is accepted. The valid stays high across back-to-back items, so it
    // is never lowered and raised again within one time step.
    task automatic send_item(logic k, logic signed [15:0] re, logic signed [15:0] im);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        sample_real <= re;
        sample_imag <= im;
        do @(posedge clk); while (!in_ready);
        sb.note_item(k, re, im);
        items_sent++;
    endtask

    task automatic send_load(logic signed [15:0] re, logic signed [15:0] im);
        send_item(fpr2_pkg::KIND_LOAD, re, im);
    endtask

    task automatic send_read();
        send_item(fpr2_pkg::KIND_READ, 16'($urandom), 16'($urandom));
    endtask

    // Holds the sender until every expected result has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Registers are written only with the block idle. A load can start a
    // transform without causing a result, so a short pause follows the
    // drain; the handshake itself covers the rest of a long transform.
    task automatic write_reg(logic [fpr2_pkg::CFG_IDX_W-1:0] idx,
                             logic [fpr2_pkg::CFG_DATA_W-1:0] data);
        drain();
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_mode(int lg, bit inverse);
        write_reg(fpr2_pkg::CFG_LOG2_SIZE, lg[fpr2_pkg::CFG_DATA_W-1:0]);
        write_reg(fpr2_pkg::CFG_INVERSE, {3'b000, inverse});
    endtask

    // One frame: n loads with occasional early reads mixed in (not ready but
    // for one before the first load while the last frame has bins left), then
    // the requested number of reads; more than n runs past the frame's end.
    task automatic run_frame(int n, int reads, int noise_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < noise_pct) send_read();
            send_load(draw_sample(), draw_sample());
        end
        for (int i = 0; i < reads; i++) send_read();
    endtask

    // The receiver stalls at random per item; when asked it holds off for a
    // long stretch so that the output register fills and the input stalls.
    initial begin
        bin_t got;
        int   stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            if (hold_request) begin
                stall = 400;
                hold_request = 0;
                long_holds++;
            end
            else
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.re = out_real;
            got.im = out_imag;
            got.idx = out_index;
            got.last = last_bin;
            got.nrdy = not_ready;
            sb.check_bin(got);
        end
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int lg, n;
        sb = new();
        items_sent = 0;
        long_holds = 0;
        hold_request = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = fpr2_pkg::KIND_LOAD;
        sample_real = '0;
        sample_imag = '0;
        cfg_valid = 1'b0;
        cfg_index = fpr2_pkg::CFG_LOG2_SIZE;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Length one: a read before any load, the single sample passing
        // unchanged, and a read past the end of the frame.
        set_mode(0, 0);
        send_read();
        send_load(16'sh7FFF, 16'sh8000);
        send_read();
        send_read();
        send_load(16'sh8000, 16'sh7FFF);
        send_read();

        // Two points, inverse, extremes on both parts so the differences wrap.
        set_mode(1, 1);
        send_load(16'sh8000, 16'sh8000);
        send_load(16'sh7FFF, 16'sh7FFF);
        send_read();
        send_read();
        send_read();

        // Four points, forward: a read during loading, a partial read and
        // then a load that drops the remaining bins.
        set_mode(2, 0);
        send_load(16'sh7FFF, 16'sh0000);
        send_read();
        send_load(16'sh8000, 16'shFFFF);
        send_load(16'sh0001, 16'sh7FFF);
        send_load(16'shFFFF, 16'sh8000);
        send_read();
        send_read();
        send_load(16'sh1234, 16'shEDCB);
        send_read();

        // Largest length, with a size value above the limit that saturates.
        // Only a slice of the bins is read before the frame is abandoned.
        set_mode(15, 1);
        run_frame(POINTS, 40, 1);
        set_mode(10, 0);
        run_frame(POINTS / 4, 0, 0);

        // Random frames of small lengths; the first one also holds off the
        // receiver for a long stretch while reads keep coming. Longer frames
        // are drawn only while the item budget leaves room for them.
        while (items_sent < TARGET_ITEMS) begin
            if (($urandom_range(0, 9) == 0) && (TARGET_ITEMS - items_sent > 600))
                lg = $urandom_range(7, 8);
            else
                lg = $urandom_range(0, 5);
            n = 1 << lg;
            set_mode(lg, 1'($urandom_range(0, 1)));
            if (long_holds == 0) begin
                run_frame(n, 0, 0);
                hold_request = 1;
                run_frame(0, n + 2, 0);
                drain();
            end
            else begin
                // Usually read the whole frame; sometimes stop short or run over.
                case ($urandom_range(0, 5))
                    0: run_frame(n, $urandom_range(0, n), 10);
                    1: run_frame(n, n + $urandom_range(1, 3), 10);
                    default: run_frame(n, n, 10);
                endcase
                if ($urandom_range(0, 2) == 0) run_frame(n, n, 5);
            end
        end

        drain();
        repeat (50) @(posedge clk);
        $display("Ran %0d items over %0d transforms, checked %0d results (%0d not ready).",
                 items_sent, sb.frames, sb.checked, sb.not_ready_seen);
        $display("Lengths 1 to 1024 in both directions, with %0d long receiver hold-offs.",
                 long_holds);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
